>>> design/tuna_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuna_pkg
// Shared constants for the triangle normal and area unit.
// ----------------------------------------------------------------------------
package tuna_pkg;

  localparam int unsigned CoordWidthDef     = 16;
  localparam int unsigned NormalFracBitsDef = 14;
  localparam int unsigned NormalWidth       = 16;
  localparam int unsigned AreaWidth         = 33;

endpackage

>>> design/triangle_unit_normal_area_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_area_unit
// Unit normal (Q1.NORMAL_FRAC_BITS) and area of a triangle from its corners.
// ----------------------------------------------------------------------------
// A new triangle is taken every cycle; busy stays low. Each word passes
// 2*COORD_WIDTH + NORMAL_FRAC_BITS + 10 register stages. These are five front
// stages, a square-root chain of 2*COORD_WIDTH + 3 cells (one root bit per
// cell), a division chain of NORMAL_FRAC_BITS + 1 cells (one quotient bit per
// cell) and the output register. The first stage loads on the accepting edge,
// and done_o is registered in the output register together with the result.
// The result lasts one cycle and cannot be held off.
module triangle_unit_normal_area_unit #(
  parameter int unsigned COORD_WIDTH      = tuna_pkg::CoordWidthDef,
  parameter int unsigned NORMAL_FRAC_BITS = tuna_pkg::NormalFracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] origin_x_i,
  input  logic [COORD_WIDTH-1:0] origin_y_i,
  input  logic [COORD_WIDTH-1:0] origin_z_i,
  input  logic [COORD_WIDTH-1:0] left_x_i,
  input  logic [COORD_WIDTH-1:0] left_y_i,
  input  logic [COORD_WIDTH-1:0] left_z_i,
  input  logic [COORD_WIDTH-1:0] right_x_i,
  input  logic [COORD_WIDTH-1:0] right_y_i,
  input  logic [COORD_WIDTH-1:0] right_z_i,
  output logic                   done_o,
  output logic signed [tuna_pkg::NormalWidth-1:0] normal_x_o,
  output logic signed [tuna_pkg::NormalWidth-1:0] normal_y_o,
  output logic signed [tuna_pkg::NormalWidth-1:0] normal_z_o,
  output logic [tuna_pkg::AreaWidth-1:0]          area_o,
  output logic                   degenerate_o
);

  import tuna_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;     // edge component
  localparam int unsigned PW = 2 * DW;              // edge product
  localparam int unsigned CW = PW + 1;              // cross component
  localparam int unsigned MW = PW;                  // cross magnitude
  localparam int unsigned SW = 2 * MW + 2;          // sum of squares
  localparam int unsigned RW = MW + 1;              // root width
  localparam int unsigned QW = NORMAL_FRAC_BITS + 1;
  localparam int unsigned HW = MW / 2 + 1;          // square split

  // Stage 1: edge vectors.
  logic                 v1_q;
  logic signed [DW-1:0] rx_q, ry_q, rz_q, lx_q, ly_q, lz_q;

  always_ff @(posedge clk_i) begin
    rx_q <= DW'($signed(right_x_i)) - DW'($signed(origin_x_i));
    ry_q <= DW'($signed(right_y_i)) - DW'($signed(origin_y_i));
    rz_q <= DW'($signed(right_z_i)) - DW'($signed(origin_z_i));
    lx_q <= DW'($signed(left_x_i))  - DW'($signed(origin_x_i));
    ly_q <= DW'($signed(left_y_i))  - DW'($signed(origin_y_i));
    lz_q <= DW'($signed(left_z_i))  - DW'($signed(origin_z_i));
  end

  // Stage 2: six products.
  logic                 v2_q;
  logic signed [PW-1:0] p_q [6];

  always_ff @(posedge clk_i) begin
    p_q[0] <= PW'(ry_q * lz_q);
    p_q[1] <= PW'(rz_q * ly_q);
    p_q[2] <= PW'(rz_q * lx_q);
    p_q[3] <= PW'(rx_q * lz_q);
    p_q[4] <= PW'(rx_q * ly_q);
    p_q[5] <= PW'(ry_q * lx_q);
  end

  // Stage 3: cross product magnitudes and signs.
  logic                 v3_q;
  logic signed [CW-1:0] c_d [3];
  logic [MW-1:0]        a_q [3];
  logic [2:0]           neg_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_d[k] = CW'(p_q[2*k]) - CW'(p_q[2*k+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      a_q[k]   <= c_d[k][CW-1] ? MW'(-c_d[k]) : MW'(c_d[k]);
      neg_q[k] <= c_d[k][CW-1];
    end
  end

  // Stage 4: squares split in halves so that each multiplier stays narrow.
  logic               v4_q;
  logic [2*HW-1:0]    sq_hh_q [3], sq_hl_q [3], sq_ll_q [3];
  logic [3*MW-1:0]    mag4_q;
  logic [2:0]         neg4_q;
  logic [HW-1:0]      ah [3], al [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ah[k] = HW'(a_q[k] >> HW);
      al[k] = HW'(a_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_hh_q[k] <= ah[k] * ah[k];
      sq_hl_q[k] <= ah[k] * al[k];
      sq_ll_q[k] <= al[k] * al[k];
      mag4_q[k*MW +: MW] <= a_q[k];
    end
    neg4_q <= neg_q;
  end

  // Stage 5: sum of squares.
  logic            v5_q;
  logic [SW-1:0]   sum_q;
  logic [SW-1:0]   sum_d;
  logic [3*MW-1:0] mag5_q;
  logic [2:0]      neg5_q;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 3; k++) begin
      sum_d = sum_d + (SW'(sq_hh_q[k]) << (2 * HW))
                    + (SW'(sq_hl_q[k]) << (HW + 1))
                    + SW'(sq_ll_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    mag5_q <= mag4_q;
    neg5_q <= neg4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Square-root chain.
  logic            sv   [RW+1];
  logic [SW-1:0]   srad [RW+1];
  logic [RW-1:0]   sroot[RW+1];
  logic [RW+1:0]   srem [RW+1];
  logic [3*MW-1:0] smag [RW+1];
  logic [2:0]      sneg [RW+1];

  assign sv[0]    = v5_q;
  assign srad[0]  = sum_q;
  assign sroot[0] = '0;
  assign srem[0]  = '0;
  assign smag[0]  = mag5_q;
  assign sneg[0]  = neg5_q;

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    tuna_sqrt_cell #(
      .SumWidth (SW),
      .RootWidth(RW),
      .CompWidth(MW),
      .Step     (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sv[g]),
      .rad_i  (srad[g]),
      .root_i (sroot[g]),
      .rem_i  (srem[g]),
      .mag_i  (smag[g]),
      .neg_i  (sneg[g]),
      .valid_o(sv[g+1]),
      .rad_o  (srad[g+1]),
      .root_o (sroot[g+1]),
      .rem_o  (srem[g+1]),
      .mag_o  (smag[g+1]),
      .neg_o  (sneg[g+1])
    );
  end

  // Division chain. |c| <= m, so the integer part is one bit handled by the
  // first cell; the rest give the fraction bits. A zero root is forced to one
  // so the chain stays defined; the output stage blanks the result.
  localparam int unsigned EW = RW + 1;
  logic               dv   [QW+1];
  logic [RW-1:0]      dmag [QW+1];
  logic [3*EW-1:0]    drem [QW+1];
  logic [3*QW-1:0]    dquot[QW+1];
  logic [2:0]         dneg [QW+1];
  logic [RW-1:0]      root_f;
  logic [RW-1:0]      area_src;
  logic [RW-1:0]      area_pipe [QW+1];

  assign root_f = sroot[RW];

  // The remainders start from the cross magnitudes themselves.
  assign drem[0] = {EW'(smag[RW][2*MW +: MW]), EW'(smag[RW][MW +: MW]),
                    EW'(smag[RW][0 +: MW])};

  assign dv[0]    = sv[RW];
  assign dmag[0]  = (root_f == '0) ? RW'(1) : root_f;
  assign dquot[0] = '0;
  assign dneg[0]  = sneg[RW];
  assign area_pipe[0] = root_f;
  assign area_src = area_pipe[QW];

  // The integer bit: |c| >= m gives 1 (only when |c| == m), then remainder 0.
  logic [3*EW-1:0] int_rem;
  logic [3*QW-1:0] int_quot;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (drem[0][k*EW +: EW] >= EW'(dmag[0])) begin
        int_rem[k*EW +: EW]  = drem[0][k*EW +: EW] - EW'(dmag[0]);
        int_quot[k*QW +: QW] = QW'(1);
      end else begin
        int_rem[k*EW +: EW]  = drem[0][k*EW +: EW];
        int_quot[k*QW +: QW] = '0;
      end
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    if (g == 0) begin : g_int
      logic            v_q;
      logic [RW-1:0]   m_q;
      logic [3*EW-1:0] r_q;
      logic [3*QW-1:0] q_q;
      logic [2:0]      n_q;
      logic [RW-1:0]   a_q2;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q <= 1'b0;
        end else begin
          v_q <= dv[0];
        end
      end
      always_ff @(posedge clk_i) begin
        m_q  <= dmag[0];
        r_q  <= int_rem;
        q_q  <= int_quot;
        n_q  <= dneg[0];
        a_q2 <= area_pipe[0];
      end
      assign dv[1]        = v_q;
      assign dmag[1]      = m_q;
      assign drem[1]      = r_q;
      assign dquot[1]     = q_q;
      assign dneg[1]      = n_q;
      assign area_pipe[1] = a_q2;
    end else begin : g_frac
      logic [RW-1:0] a_q2;
      tuna_div_cell #(
        .RootWidth(EW - 1),
        .QuotWidth(QW)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .valid_i(dv[g]),
        .mag_i  (dmag[g]),
        .rem_i  (drem[g]),
        .quot_i (dquot[g]),
        .neg_i  (dneg[g]),
        .valid_o(dv[g+1]),
        .mag_o  (dmag[g+1]),
        .rem_o  (drem[g+1]),
        .quot_o (dquot[g+1]),
        .neg_o  (dneg[g+1])
      );
      always_ff @(posedge clk_i) begin
        a_q2 <= area_pipe[g];
      end
      assign area_pipe[g+1] = a_q2;
    end
  end

  // Output register.
  logic                   done_q;
  logic [NormalWidth-1:0] nrm_q [3];
  logic [AreaWidth-1:0]   area_q;
  logic                   degen_q;
  logic                   zero_w;
  logic [RW-2:0]          half;

  assign zero_w = (area_src == '0);
  assign half   = area_src[RW-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (zero_w) begin
        nrm_q[k] <= '0;
      end else if (dneg[QW][k]) begin
        nrm_q[k] <= NormalWidth'(-{{NormalWidth{1'b0}}, dquot[QW][k*QW +: QW]});
      end else begin
        nrm_q[k] <= NormalWidth'({{NormalWidth{1'b0}}, dquot[QW][k*QW +: QW]});
      end
    end
    if (RW - 1 > AreaWidth && (half >> AreaWidth) != '0) begin
      area_q <= '1;
    end else begin
      area_q <= AreaWidth'({{AreaWidth{1'b0}}, half});
    end
    degen_q <= zero_w;
  end

  assign busy         = 1'b0;
  assign done_o       = done_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign area_o       = area_q;
  assign degenerate_o = degen_q;

  // A zero magnitude always reports as degenerate with a blank normal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0
                               && normal_z_o == '0 && area_o == '0)
    else $error("degenerate word carries a non-zero normal or area");

  // Every result comes from a word leaving the division chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(dv[QW]))
    else $error("result without a word leaving the division chain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> $past(start, 5))
    else $error("word entered the root chain without a start");

endmodule

>>> design/tuna_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuna_sqrt_cell
// One step of the restoring integer square root: settles one root bit per
// cycle and hands the partial root, remainder and item payload onwards.
// ----------------------------------------------------------------------------
module tuna_sqrt_cell #(
  parameter int unsigned SumWidth  = 98,
  parameter int unsigned RootWidth = 49,
  parameter int unsigned CompWidth = 49,
  parameter int unsigned Step      = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [SumWidth-1:0]  rad_i,
  input  logic [RootWidth-1:0] root_i,
  input  logic [RootWidth+1:0] rem_i,
  input  logic [3*CompWidth-1:0] mag_i,
  input  logic [2:0]           neg_i,
  output logic                 valid_o,
  output logic [SumWidth-1:0]  rad_o,
  output logic [RootWidth-1:0] root_o,
  output logic [RootWidth+1:0] rem_o,
  output logic [3*CompWidth-1:0] mag_o,
  output logic [2:0]           neg_o
);

  // Bit pair of the radicand consumed at this step, from the top down.
  localparam int unsigned PairLo = 2 * (RootWidth - 1 - Step);

  logic                 valid_q;
  logic [SumWidth-1:0]  rad_q;
  logic [RootWidth-1:0] root_q, root_d;
  logic [RootWidth+1:0] rem_q, rem_d, trial;
  logic [RootWidth+1:0] shifted;
  logic [3*CompWidth-1:0] mag_q;
  logic [2:0]           neg_q;

  always_comb begin
    shifted = {rem_i[RootWidth-1:0], rad_i[PairLo+1 -: 2]};
    trial   = {root_i, 2'b01};
    if (shifted >= trial) begin
      rem_d  = shifted - trial;
      root_d = {root_i[RootWidth-2:0], 1'b1};
    end else begin
      rem_d  = shifted;
      root_d = {root_i[RootWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_i;
    root_q <= root_d;
    rem_q  <= rem_d;
    mag_q  <= mag_i;
    neg_q  <= neg_i;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign root_o  = root_q;
  assign rem_o   = rem_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

>>> design/tuna_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuna_div_cell
// One restoring division step for all three normal components at once: each
// cycle settles one quotient bit per component against the shared magnitude.
// ----------------------------------------------------------------------------
module tuna_div_cell #(
  parameter int unsigned RootWidth = 49,
  parameter int unsigned QuotWidth = 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [RootWidth-1:0]   mag_i,
  input  logic [3*(RootWidth+1)-1:0] rem_i,
  input  logic [3*QuotWidth-1:0] quot_i,
  input  logic [2:0]             neg_i,
  output logic                   valid_o,
  output logic [RootWidth-1:0]   mag_o,
  output logic [3*(RootWidth+1)-1:0] rem_o,
  output logic [3*QuotWidth-1:0] quot_o,
  output logic [2:0]             neg_o
);

  localparam int unsigned RemWidth = RootWidth + 1;

  logic                   valid_q;
  logic [RootWidth-1:0]   mag_q;
  logic [3*RemWidth-1:0]  rem_q, rem_d;
  logic [3*QuotWidth-1:0] quot_q, quot_d;
  logic [2:0]             neg_q;
  logic [RemWidth:0]      shifted [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shifted[k] = {rem_i[k*RemWidth +: RemWidth], 1'b0};
      if (shifted[k] >= {2'b00, mag_i}) begin
        rem_d[k*RemWidth +: RemWidth] = RemWidth'(shifted[k] - {2'b00, mag_i});
        quot_d[k*QuotWidth +: QuotWidth] =
          {quot_i[k*QuotWidth +: QuotWidth-1], 1'b1};
      end else begin
        rem_d[k*RemWidth +: RemWidth] = RemWidth'(shifted[k]);
        quot_d[k*QuotWidth +: QuotWidth] =
          {quot_i[k*QuotWidth +: QuotWidth-1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_i;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    neg_q  <= neg_i;
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign rem_o   = rem_q;
  assign quot_o  = quot_q;
  assign neg_o   = neg_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle unit normal and area unit.
// Triangles are sent through the start/busy handshake with random gaps. Each
// accepted triangle is run through an exact integer model of the cross
// product, the square root and the scaled division. Every done_o word is
// compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CW         = tuna_pkg::CoordWidthDef;
  localparam int unsigned FracBits   = tuna_pkg::NormalFracBitsDef;
  localparam int unsigned NW         = tuna_pkg::NormalWidth;
  localparam int unsigned AW         = tuna_pkg::AreaWidth;
  localparam int unsigned CornerBits = 9 * CW;
  localparam int          Latency    = 2 * CW + FracBits + 9;
  localparam int          NumRandom  = 600;
  localparam longint      CycleCap   = 400000;

  typedef struct packed {
    logic [CW-1:0] ox, oy, oz, lx, ly, lz, rx, ry, rz;
  } corners_t;

  typedef struct packed {
    logic [NW-1:0] nx, ny, nz;
    logic [AW-1:0] area;
    logic          degen;
  } face_t;

  class face_scoreboard;
    face_t  pending_faces[$];
    int     mismatches;
    int     words_checked;
    int     degen_seen;

    function longint sx(logic [CW-1:0] v);
      return longint'($signed(v));
    endfunction

    function logic [NW-1:0] scaled_component(longint c, logic [127:0] mag);
      logic [127:0] a, q;
      a = (c < 0) ? 128'(-c) : 128'(c);
      q = (a << FracBits) / mag;
      if (c < 0) q = -q;
      return q[NW-1:0];
    endfunction

    function face_t predict_face(corners_t t);
      longint       erx, ery, erz, elx, ely, elz;
      longint       c[3];
      logic [127:0] sum, root, cand, a;
      face_t        f;
      erx = sx(t.rx) - sx(t.ox);
      ery = sx(t.ry) - sx(t.oy);
      erz = sx(t.rz) - sx(t.oz);
      elx = sx(t.lx) - sx(t.ox);
      ely = sx(t.ly) - sx(t.oy);
      elz = sx(t.lz) - sx(t.oz);
      c[0] = ery * elz - erz * ely;
      c[1] = erz * elx - erx * elz;
      c[2] = erx * ely - ery * elx;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
        a = (c[k] < 0) ? 128'(-c[k]) : 128'(c[k]);
        sum = sum + a * a;
      end
      f = '0;
      if (sum == 0) begin
        f.degen = 1'b1;
        return f;
      end
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= sum) root = cand;
      end
      f.nx = scaled_component(c[0], root);
      f.ny = scaled_component(c[1], root);
      f.nz = scaled_component(c[2], root);
      // The area cannot exceed the field with 16-bit corners, but clamp anyway.
      f.area = ((root >> 1) > {AW{1'b1}}) ? {AW{1'b1}} : AW'(root >> 1);
      return f;
    endfunction

    function void note_triangle(corners_t t);
      pending_faces.push_back(predict_face(t));
    endfunction

    function void check_face(face_t got);
      face_t want;
      if (pending_faces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected word %h", got);
        return;
      end
      want = pending_faces.pop_front();
      words_checked++;
      if (want.degen) degen_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: word %0d nx %0d/%0d ny %0d/%0d nz %0d/%0d",
                    " area %0d/%0d degen %0b/%0b"},
                   words_checked, $signed(want.nx), $signed(got.nx),
                   $signed(want.ny), $signed(got.ny), $signed(want.nz),
                   $signed(got.nz), want.area, got.area, want.degen, got.degen);
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  corners_t      corners = '0;
  logic          done_o;
  logic [NW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic [AW-1:0] area_o;
  logic          degenerate_o;
  longint        cycles = 0;
  int            triangles_sent = 0;
  bit            no_gaps = 1'b0;

  face_scoreboard sb = new();

  triangle_unit_normal_area_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .origin_x_i  (corners.ox),
    .origin_y_i  (corners.oy),
    .origin_z_i  (corners.oz),
    .left_x_i    (corners.lx),
    .left_y_i    (corners.ly),
    .left_z_i    (corners.lz),
    .right_x_i   (corners.rx),
    .right_y_i   (corners.ry),
    .right_z_i   (corners.rz),
    .done_o      (done_o),
    .normal_x_o  (normal_x_o),
    .normal_y_o  (normal_y_o),
    .normal_z_o  (normal_z_o),
    .area_o      (area_o),
    .degenerate_o(degenerate_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("ERROR: run timed out");
      $display("status: fail");
      $finish;
    end
    if (rst_ni && done_o)
      sb.check_face({normal_x_o, normal_y_o, normal_z_o, area_o, degenerate_o});
  end

  // Start stays high across back-to-back words; it drops only for a gap.
  task automatic send_triangle(corners_t t);
    int gap;
    corners = t;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_triangle(t);
    triangles_sent++;
    @(negedge clk_i);
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(20, 70);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      start = 1'b0;
      corners = corners_t'(CornerBits'({$urandom, $urandom, $urandom, $urandom,
                                        $urandom}));
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic corners_t make_tri(int ox, int oy, int oz, int lx, int ly, int lz,
                                        int rx, int ry, int rz);
    corners_t t;
    t = {CW'(ox), CW'(oy), CW'(oz), CW'(lx), CW'(ly), CW'(lz), CW'(rx), CW'(ry), CW'(rz)};
    return t;
  endfunction

  function automatic int small_coord();
    return $urandom_range(0, 64) - 32;
  endfunction

  task automatic send_random_triangle();
    corners_t t;
    int       ox, oy, oz, dx, dy, dz, j, k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3:
        t = corners_t'(CornerBits'({$urandom, $urandom, $urandom, $urandom,
                                    $urandom}));
      4, 5, 6: begin
        ox = $urandom_range(0, 65535) - 32768;
        oy = $urandom_range(0, 65535) - 32768;
        oz = $urandom_range(0, 65535) - 32768;
        t = make_tri(ox, oy, oz, ox + small_coord(), oy + small_coord(), oz + small_coord(),
                     ox + small_coord(), oy + small_coord(), oz + small_coord());
      end
      7, 8: begin
        // Collinear corners give a zero cross product.
        ox = small_coord() * 100;
        oy = small_coord() * 100;
        oz = small_coord() * 100;
        dx = small_coord();
        dy = small_coord();
        dz = small_coord();
        j = $urandom_range(0, 20) - 10;
        k = $urandom_range(0, 20) - 10;
        t = make_tri(ox, oy, oz, ox + j * dx, oy + j * dy, oz + j * dz,
                     ox + k * dx, oy + k * dy, oz + k * dz);
      end
      default: begin
        // Axis-aligned edges, so the normal lands on an axis exactly.
        ox = small_coord();
        oy = small_coord();
        oz = small_coord();
        j = $urandom_range(1, 30000);
        k = $urandom_range(1, 30000);
        t = make_tri(ox, oy, oz, ox, oy + k, oz, ox + j, oy, oz);
      end
    endcase
    send_triangle(t);
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    no_gaps = 1'b1;
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_tri(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_triangle(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
    send_triangle(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
    send_triangle(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
    send_triangle(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_triangle(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                           -32768, 32767, -32768));
    send_triangle(make_tri(-32768, -32768, -32768, 32767, -32768, 32767,
                           -32768, 32767, 32767));
    send_triangle(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                           32767, 32767, -32768));
    send_triangle(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                           32767, 32767, 32767));
    send_triangle(make_tri(0, 0, 0, 1, 1, 1, 1, 1, 0));
    send_triangle(make_tri(5, -7, 3, 5, -7, 3, 100, 200, 300));
    no_gaps = 1'b0;
    send_triangle(make_tri(-1, -1, -1, 0, -1, -1, -1, 0, -1));
    send_triangle(make_tri(100, -200, 300, -400, 500, -600, 700, 800, -900));

    for (int i = 0; i < NumRandom; i++) begin
      // Every so often run a stretch with start held high.
      if (i % 100 == 50) no_gaps = 1'b1;
      if (i % 100 == 80) no_gaps = 1'b0;
      send_random_triangle();
    end
    start = 1'b0;

    waited = 0;
    while (sb.pending_faces.size() != 0 && waited < 20 * Latency) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Latency + 10) @(posedge clk_i);

    $display("Sent %0d triangles, checked %0d words, %0d of them degenerate.",
             triangles_sent, sb.words_checked, sb.degen_seen);
    $display("Mismatches: %0d, predictions left over: %0d.",
             sb.mismatches, sb.pending_faces.size());
    if (sb.mismatches == 0 && sb.pending_faces.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
